// ===== hw/rtl/gjs_pkg.sv =====
// Shared constants, codes and saturation helper for the Gauss-Jordan solver.
package gjs_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 4;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_SOLVE = 2'd2;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_SOLVE = 2'd2;

    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_COL_COUNT = 1'b1;

    // Give magnitude m its sign and clamp to 32-bit signed range.
    function automatic logic [DATA_W-1:0] f_signed_sat(input logic [63:0] m, input logic neg);
        logic [DATA_W-1:0] res;
        if (neg) begin
            if (m >= (64'd1 << 31)) begin
                res = 32'h8000_0000;
            end else begin
                res = 32'd0 - m[DATA_W-1:0];
            end
        end else begin
            if (m > 64'h0000_0000_7FFF_FFFF) begin
                res = 32'h7FFF_FFFF;
            end else begin
                res = m[DATA_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/gjs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gjs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 72
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/gjs_div.sv =====
// Bit-serial divider forming the saturated fixed-point quotient -x/p.
module gjs_div import gjs_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_x,
    input  logic [DATA_W-1:0] i_p,
    output logic              o_done,
    output logic [DATA_W-1:0] o_q
);

    localparam int NW  = DATA_W + 1 + FRAC_BITS;
    localparam int CNW = $clog2(NW + 1);

    logic [NW-1:0]     r_num;
    logic [DATA_W-1:0] r_den;
    logic [DATA_W-1:0] r_rem;
    logic [CNW-1:0]    r_cnt;
    logic              r_run;
    logic              r_done;
    logic              r_neg;

    logic [DATA_W-1:0] mag_x;
    logic [DATA_W-1:0] mag_p;
    logic [NW-1:0]     num;
    logic [DATA_W:0]   rem_sh;
    logic              q_bit;

    always_comb begin
        mag_x  = i_x[DATA_W-1] ? (32'd0 - i_x) : i_x;
        mag_p  = i_p[DATA_W-1] ? (32'd0 - i_p) : i_p;
        num    = (NW'(mag_x) << FRAC_BITS) + NW'(mag_p >> 1);
        rem_sh = {r_rem, r_num[NW-1]};
        q_bit  = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num <= num;
                r_den <= mag_p;
                r_rem <= '0;
                r_neg <= (i_x[DATA_W-1] == i_p[DATA_W-1]);
                r_cnt <= CNW'(NW);
                r_run <= 1'b1;
            end else if (r_run) begin
                // shift one quotient bit into the numerator register
                r_rem <= q_bit ? DATA_W'(rem_sh - {1'b0, r_den}) : rem_sh[DATA_W-1:0];
                r_num <= {r_num[NW-2:0], q_bit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = f_signed_sat(64'(r_num), r_neg);

endmodule

// ===== hw/rtl/gauss_jordan_linear_solver.sv =====
// Gauss-Jordan solver top level: matrix store, command handling and elimination sequencer.
// Write and read items each give a result that strobes on the cycle after accept.
// Solve walks the matrix one element at a time over the single RAM; each eliminated element
// is read, multiplied, rounded and written; pivot-row elements use the serial divider.
// busy stays high for the whole solve; the solve result strobes as busy falls, no stall.
// Synchronous active-low reset sets row_count 1, col_count 2; the matrix is not cleared.
module gauss_jordan_linear_solver import gjs_pkg::*; #(
    parameter int MAX_ROWS  = 8,
    parameter int MAX_COLS  = 9,
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic [1:0]        i_operation,
    input  logic [3:0]        i_row_index,
    input  logic [3:0]        i_col_index,
    input  logic [DATA_W-1:0] i_element_value,
    output logic              o_result_valid,
    output logic [1:0]        o_result_kind,
    output logic [DATA_W-1:0] o_read_value,
    output logic              o_solvable
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam logic [DATA_W-1:0] ONE     = DATA_W'(1) << FRAC_BITS;
    localparam logic [DATA_W-1:0] NEG_ONE = DATA_W'(0) - ONE;

    typedef enum logic [4:0] {
        S_IDLE, S_PV_RD, S_PV_CHK, S_SR_RD, S_SR_CHK,
        S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB,
        S_SC_RD, S_SC_DIV, S_SC_WAIT,
        S_EM_RD, S_EM_CHK, S_E_RA, S_E_RB, S_E_MUL, S_E_RND, S_E_WR, S_ROW_NEXT,
        S_NEXT_K, S_BK_RD, S_BK_CHK, S_BK_NEXT, S_CK_RD, S_CK_CHK
    } t_state;

    t_state r_state;

    logic [CFG_W-1:0]  r_row_count;
    logic [CFG_W-1:0]  r_col_count;
    logic [RCW-1:0]    r_rows, r_n, r_k, r_r, r_rend;
    logic [CW-1:0]     r_cols, r_c;
    logic              r_back;
    logic [DATA_W-1:0] r_p, r_tmp, r_a, r_m, r_x, r_mq;
    logic [63:0]       r_prod;
    logic              r_nz, r_bad;

    logic              r_out_valid;
    logic [1:0]        r_out_kind;
    logic              r_rd_inside;
    logic              r_out_solvable;

    logic [RCW-1:0]    eff_rows;
    logic [CW-1:0]     eff_cols;
    logic              in_range;
    logic              accept;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    logic              div_start, div_done;
    logic [DATA_W-1:0] div_q;

    logic [63:0]       prod_mag;
    logic [63:0]       prod_rnd;
    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] sum_sat;

    function automatic logic [AW-1:0] f_addr(input int row, input int col);
        return AW'(row * MAX_COLS + col);
    endfunction

    always_comb begin
        if (r_row_count == '0) begin
            eff_rows = RCW'(1);
        end else if (int'(r_row_count) > MAX_ROWS) begin
            eff_rows = RCW'(MAX_ROWS);
        end else begin
            eff_rows = RCW'(r_row_count);
        end
        if (r_col_count == '0) begin
            eff_cols = CW'(1);
        end else if (int'(r_col_count) > MAX_COLS) begin
            eff_cols = CW'(MAX_COLS);
        end else begin
            eff_cols = CW'(r_col_count);
        end
        in_range = (int'(i_row_index) < int'(eff_rows)) && (int'(i_col_index) < int'(eff_cols));
        accept = i_start && (r_state == S_IDLE);
    end

    // saturating multiply-add datapath
    always_comb begin
        prod_mag = r_prod[63] ? (64'd0 - r_prod) : r_prod;
        prod_rnd = (prod_mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        sum      = {r_x[DATA_W-1], r_x} + {r_mq[DATA_W-1], r_mq};
        if (sum[DATA_W] != sum[DATA_W-1]) begin
            sum_sat = sum[DATA_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            sum_sat = sum[DATA_W-1:0];
        end
    end

    always_comb begin
        ram_raddr = '0;
        case (r_state)
            S_IDLE:           ram_raddr = f_addr(int'(i_row_index), int'(i_col_index));
            S_PV_RD, S_BK_RD: ram_raddr = f_addr(int'(r_k), int'(r_k));
            S_SR_RD, S_EM_RD: ram_raddr = f_addr(int'(r_r), int'(r_k));
            S_SW_RA, S_SC_RD, S_E_RA: ram_raddr = f_addr(int'(r_k), int'(r_c));
            S_SW_RB, S_E_RB, S_CK_RD: ram_raddr = f_addr(int'(r_r), int'(r_c));
            default:          ram_raddr = '0;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        case (r_state)
            S_IDLE: begin
                ram_we    = accept && (i_operation == OP_WRITE) && in_range;
                ram_waddr = f_addr(int'(i_row_index), int'(i_col_index));
                ram_wdata = i_element_value;
            end
            S_SW_WA: begin
                ram_we    = 1'b1;
                ram_waddr = f_addr(int'(r_k), int'(r_c));
                ram_wdata = ram_rdata;
            end
            S_SW_WB: begin
                ram_we    = 1'b1;
                ram_waddr = f_addr(int'(r_r), int'(r_c));
                ram_wdata = r_tmp;
            end
            S_SC_WAIT: begin
                ram_we    = div_done;
                ram_waddr = f_addr(int'(r_k), int'(r_c));
                ram_wdata = (int'(r_c) == int'(r_k)) ? NEG_ONE : div_q;
            end
            S_E_WR: begin
                ram_we    = 1'b1;
                ram_waddr = f_addr(int'(r_r), int'(r_c));
                ram_wdata = (int'(r_c) == int'(r_k)) ? '0 : sum_sat;
            end
            default: ram_we = 1'b0;
        endcase
    end

    assign div_start = (r_state == S_SC_DIV);

    gjs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    gjs_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_x     (ram_rdata),
        .i_p     (r_p),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_count <= CFG_W'(1);
            r_col_count <= CFG_W'(2);
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ROW_COUNT) begin
                    r_row_count <= i_cfg_data;
                end else begin
                    r_col_count <= i_cfg_data;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_rd_inside    <= in_range;
                        r_out_solvable <= 1'b0;
                        if (i_operation == OP_WRITE) begin
                            r_out_valid <= 1'b1;
                            r_out_kind  <= KIND_WRITE;
                        end else if (i_operation == OP_READ) begin
                            r_out_valid <= 1'b1;
                            r_out_kind  <= KIND_READ;
                        end else if (i_operation == OP_SOLVE) begin
                            r_rows <= eff_rows;
                            r_cols <= eff_cols;
                            r_bad  <= 1'b0;
                            r_k    <= '0;
                            if (int'(eff_cols) - 1 < int'(eff_rows)) begin
                                r_n <= RCW'(int'(eff_cols) - 1);
                            end else begin
                                r_n <= eff_rows;
                            end
                            if (eff_cols == CW'(1)) begin
                                r_r     <= '0;
                                r_c     <= '0;
                                r_nz    <= 1'b0;
                                r_state <= S_CK_RD;
                            end else begin
                                r_state <= S_PV_RD;
                            end
                        end
                    end
                end
                S_PV_RD: r_state <= S_PV_CHK;
                S_PV_CHK: begin
                    if (ram_rdata != '0) begin
                        r_p     <= ram_rdata;
                        r_c     <= '0;
                        r_state <= S_SC_RD;
                    end else begin
                        r_r     <= r_k + 1'b1;
                        r_state <= (int'(r_k) + 1 < int'(r_rows)) ? S_SR_RD : S_NEXT_K;
                    end
                end
                S_SR_RD: r_state <= S_SR_CHK;
                S_SR_CHK: begin
                    if (ram_rdata != '0) begin
                        r_p     <= ram_rdata;
                        r_c     <= '0;
                        r_state <= S_SW_RA;
                    end else begin
                        r_r     <= r_r + 1'b1;
                        r_state <= (int'(r_r) + 1 < int'(r_rows)) ? S_SR_RD : S_NEXT_K;
                    end
                end
                S_SW_RA: r_state <= S_SW_RB;
                S_SW_RB: begin
                    r_tmp   <= ram_rdata;
                    r_state <= S_SW_WA;
                end
                S_SW_WA: r_state <= S_SW_WB;
                S_SW_WB: begin
                    // swap whole rows, columns beyond the ones in use too
                    if (int'(r_c) + 1 < MAX_COLS) begin
                        r_c     <= r_c + 1'b1;
                        r_state <= S_SW_RA;
                    end else begin
                        r_c     <= '0;
                        r_state <= S_SC_RD;
                    end
                end
                S_SC_RD:  r_state <= S_SC_DIV;
                S_SC_DIV: r_state <= S_SC_WAIT;
                S_SC_WAIT: begin
                    if (div_done) begin
                        if (int'(r_c) + 1 < int'(r_cols)) begin
                            r_c     <= r_c + 1'b1;
                            r_state <= S_SC_RD;
                        end else begin
                            // pivot row done: eliminate the rows below
                            r_r     <= r_k + 1'b1;
                            r_rend  <= r_rows;
                            r_back  <= 1'b0;
                            r_state <= (int'(r_k) + 1 < int'(r_rows)) ? S_EM_RD : S_NEXT_K;
                        end
                    end
                end
                S_EM_RD: r_state <= S_EM_CHK;
                S_EM_CHK: begin
                    r_m <= ram_rdata;
                    r_c <= '0;
                    // a zero multiplier leaves the row unchanged
                    r_state <= (ram_rdata == '0) ? S_ROW_NEXT : S_E_RA;
                end
                S_E_RA: r_state <= S_E_RB;
                S_E_RB: begin
                    r_a     <= ram_rdata;
                    r_state <= S_E_MUL;
                end
                S_E_MUL: begin
                    r_x     <= ram_rdata;
                    r_prod  <= $signed({{DATA_W{r_a[DATA_W-1]}}, r_a})
                             * $signed({{DATA_W{r_m[DATA_W-1]}}, r_m});
                    r_state <= S_E_RND;
                end
                S_E_RND: begin
                    r_mq    <= f_signed_sat(prod_rnd, r_prod[63]);
                    r_state <= S_E_WR;
                end
                S_E_WR: begin
                    if (int'(r_c) + 1 < int'(r_cols)) begin
                        r_c     <= r_c + 1'b1;
                        r_state <= S_E_RA;
                    end else begin
                        r_state <= S_ROW_NEXT;
                    end
                end
                S_ROW_NEXT: begin
                    r_r <= r_r + 1'b1;
                    if (int'(r_r) + 1 < int'(r_rend)) begin
                        r_state <= S_EM_RD;
                    end else begin
                        r_state <= r_back ? S_BK_NEXT : S_NEXT_K;
                    end
                end
                S_NEXT_K: begin
                    if (int'(r_k) + 1 < int'(r_n)) begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_PV_RD;
                    end else begin
                        r_state <= S_BK_RD;
                    end
                end
                S_BK_RD: r_state <= S_BK_CHK;
                S_BK_CHK: begin
                    if (ram_rdata != '0 && r_k != '0) begin
                        r_r     <= '0;
                        r_rend  <= r_k;
                        r_back  <= 1'b1;
                        r_state <= S_EM_RD;
                    end else begin
                        r_state <= S_BK_NEXT;
                    end
                end
                S_BK_NEXT: begin
                    if (r_k == '0) begin
                        r_r     <= '0;
                        r_c     <= '0;
                        r_nz    <= 1'b0;
                        r_state <= S_CK_RD;
                    end else begin
                        r_k     <= r_k - 1'b1;
                        r_state <= S_BK_RD;
                    end
                end
                S_CK_RD: r_state <= S_CK_CHK;
                S_CK_CHK: begin
                    if (int'(r_c) + 1 < int'(r_cols)) begin
                        if (ram_rdata != '0) begin
                            r_nz <= 1'b1;
                        end
                        r_c     <= r_c + 1'b1;
                        r_state <= S_CK_RD;
                    end else begin
                        // right-hand side column
                        if (!r_nz && ram_rdata != '0) begin
                            r_bad <= 1'b1;
                        end
                        r_r  <= r_r + 1'b1;
                        r_c  <= '0;
                        r_nz <= 1'b0;
                        if (int'(r_r) + 1 < int'(r_rows)) begin
                            r_state <= S_CK_RD;
                        end else begin
                            r_out_valid    <= 1'b1;
                            r_out_kind     <= KIND_SOLVE;
                            r_out_solvable <= !(r_bad || (!r_nz && ram_rdata != '0));
                            r_state        <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_solvable     = r_out_solvable;
    assign o_read_value   = (r_out_kind == KIND_READ) ? (r_rd_inside ? ram_rdata : ONE) : '0;

    a_rw_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_operation == OP_WRITE || i_operation == OP_READ)) |=> o_result_valid)
        else $error("write or read item gave no result");

    a_solve_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_operation == OP_SOLVE) |=> o_busy)
        else $error("solve did not raise busy");

    a_solve_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result_kind == KIND_SOLVE) |-> !o_busy)
        else $error("solve result while still busy");

    a_div_in_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_SC_WAIT))
        else $error("divider finished outside pivot scaling");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the Gauss-Jordan solver: random systems checked against a predictor.
module tb_top import gjs_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS_MAX = 8;
    localparam int COLS_MAX = 9;
    localparam int FRAC     = 16;
    localparam int ONE_Q    = 1 << FRAC;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic        solvable;
    } t_solver_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    logic              o_busy;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_index = 1'b0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic [1:0]        i_operation = OP_WRITE;
    logic [3:0]        i_row_index = '0;
    logic [3:0]        i_col_index = '0;
    logic [DATA_W-1:0] i_element_value = '0;
    logic              o_result_valid;
    logic [1:0]        o_result_kind;
    logic [DATA_W-1:0] o_read_value;
    logic              o_solvable;

    gauss_jordan_linear_solver u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    int              sys_matrix [ROWS_MAX][COLS_MAX];
    logic [3:0]      row_reg = 4'd1;
    logic [3:0]      col_reg = 4'd2;
    t_solver_result  pending_results [$];
    int              error_count = 0;
    int              items_sent = 0;
    int              gap_pct = 0;

    function automatic int rows_used();
        return (row_reg < 1) ? 1 : (row_reg > ROWS_MAX) ? ROWS_MAX : int'(row_reg);
    endfunction

    function automatic int cols_used();
        return (col_reg < 1) ? 1 : (col_reg > COLS_MAX) ? COLS_MAX : int'(col_reg);
    endfunction

    function automatic int clamp_mag(longint unsigned m, bit neg);
        if (neg) return (m >= 64'h8000_0000) ? 32'h8000_0000 : int'(-longint'(m));
        return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : int'(m);
    endfunction

    function automatic int add_sat(int a, int b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (s < -64'sh8000_0000) return 32'h8000_0000;
        return int'(s);
    endfunction

    function automatic int q_mul(int a, int b);
        longint          p;
        longint unsigned m;
        p = longint'(a) * longint'(b);
        m = (p < 0) ? longint'(-p) : p;
        m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
        return clamp_mag(m, p < 0);
    endfunction

    // -x/p, rounded half away from zero
    function automatic int q_neg_div(int x, int p);
        longint unsigned num, den;
        if (x == 0) return 0;
        num = ((x < 0) ? -longint'(x) : longint'(x)) << FRAC;
        den = (p < 0) ? -longint'(p) : longint'(p);
        return clamp_mag((num + den / 2) / den, (x < 0) == (p < 0));
    endfunction

    function automatic void cancel_row(int t, int p, int k, int cols);
        int m;
        m = sys_matrix[t][k];
        for (int c = 0; c < cols; c++)
            sys_matrix[t][c] = add_sat(sys_matrix[t][c], q_mul(sys_matrix[p][c], m));
        sys_matrix[t][k] = 0;
    endfunction

    function automatic bit reduce_and_check();
        int rows, cols, n, p, tmp;
        bit found, zero_coef;
        rows = rows_used();
        cols = cols_used();
        n = (cols - 1 < rows) ? cols - 1 : rows;
        for (int k = 0; k < n; k++) begin
            if (sys_matrix[k][k] == 0) begin
                found = 1'b0;
                for (int r = k + 1; r < rows && !found; r++) begin
                    if (sys_matrix[r][k] != 0) begin
                        found = 1'b1;
                        for (int c = 0; c < COLS_MAX; c++) begin
                            tmp = sys_matrix[k][c];
                            sys_matrix[k][c] = sys_matrix[r][c];
                            sys_matrix[r][c] = tmp;
                        end
                    end
                end
                if (!found) continue;
            end
            p = sys_matrix[k][k];
            for (int c = 0; c < cols; c++) sys_matrix[k][c] = q_neg_div(sys_matrix[k][c], p);
            sys_matrix[k][k] = -ONE_Q;
            for (int r = k + 1; r < rows; r++) cancel_row(r, k, k, cols);
        end
        for (int d = n - 1; d >= 0; d--) begin
            if (sys_matrix[d][d] == 0) continue;
            for (int r = 0; r < d; r++) cancel_row(r, d, d, cols);
        end
        for (int r = 0; r < rows; r++) begin
            zero_coef = 1'b1;
            for (int c = 0; c + 1 < cols; c++) if (sys_matrix[r][c] != 0) zero_coef = 1'b0;
            if (zero_coef && sys_matrix[r][cols - 1] != 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int rand_q();
        case ($urandom_range(0, 9))
            0, 1, 2: return 0;
            3: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            4: return int'($urandom);
            default: return ((int'($urandom_range(0, 16)) - 8) <<< FRAC)
                            + int'($urandom_range(0, ONE_Q - 1));
        endcase
    endfunction

    // present one item, wait for accept, record what it should produce
    task automatic send_item(logic [1:0] op, logic [3:0] r, logic [3:0] c, logic [31:0] v);
        t_solver_result exp_res;
        bit hit;
        i_start <= 1'b1;
        i_operation <= op;
        i_row_index <= r;
        i_col_index <= c;
        i_element_value <= v;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        hit = (r < rows_used()) && (c < cols_used());
        exp_res = '0;
        exp_res.kind = op;
        case (op)
            OP_WRITE: if (hit) sys_matrix[r][c] = int'(v);
            OP_READ:  exp_res.value = hit ? sys_matrix[r][c] : ONE_Q;
            OP_SOLVE: exp_res.solvable = reduce_and_check();
            default: ;
        endcase
        if (op != OP_UNUSED) begin
            pending_results.push_back(exp_res);
            items_sent++;
        end
        if ($urandom_range(0, 99) < gap_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // hold off until every result is back and the block is quiet
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [3:0] data);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ROW_COUNT) row_reg = data;
        else col_reg = data;
    endtask

    always @(posedge i_clk) begin
        t_solver_result e;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, kind %0d", $time, o_result_kind);
                error_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_result_kind !== e.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $time, e.kind, o_result_kind);
                    error_count++;
                end
                if (o_read_value !== e.value) begin
                    $display("%0t: read_value expected %h actual %h", $time, e.value,
                             o_read_value);
                    error_count++;
                end
                if (o_solvable !== e.solvable) begin
                    $display("%0t: solvable expected %0d actual %0d", $time, e.solvable,
                             o_solvable);
                    error_count++;
                end
            end
        end
    end

    // define the whole store so that no later read or solve touches unwritten words
    task automatic test_fill_store();
        write_cfg(CFG_ROW_COUNT, 4'd8);
        write_cfg(CFG_COL_COUNT, 4'd9);
        for (int r = 0; r < ROWS_MAX; r++)
            for (int c = 0; c < COLS_MAX; c++) send_item(OP_WRITE, 4'(r), 4'(c), rand_q());
    endtask

    task automatic test_directed();
        send_item(OP_WRITE, 4'd0, 4'd0, 32'h7FFF_FFFF);
        send_item(OP_WRITE, 4'd7, 4'd8, 32'h8000_0000);
        send_item(OP_READ, 4'd0, 4'd0, 32'hFFFF_FFFF);
        send_item(OP_READ, 4'd7, 4'd8, '0);
        send_item(OP_WRITE, 4'd15, 4'd15, 32'h1234_5678);
        send_item(OP_WRITE, 4'd8, 4'd2, 32'h1234_5678);
        send_item(OP_READ, 4'd15, 4'd15, '0);
        send_item(OP_READ, 4'd2, 4'd9, '0);
        send_item(OP_UNUSED, 4'd1, 4'd1, 32'hFFFF_FFFF);
        send_item(OP_SOLVE, 4'd0, 4'd0, '0);
        send_item(OP_READ, 4'd3, 4'd3, '0);
        send_item(OP_READ, 4'd0, 4'd8, '0);
        // zero registers saturate up to one row and one column
        write_cfg(CFG_ROW_COUNT, 4'd0);
        write_cfg(CFG_COL_COUNT, 4'd0);
        send_item(OP_READ, 4'd0, 4'd0, '0);
        send_item(OP_READ, 4'd0, 4'd1, '0);
        send_item(OP_WRITE, 4'd0, 4'd0, 32'h0001_0000);
        send_item(OP_SOLVE, 4'd0, 4'd0, '0);
        // oversized registers saturate down
        write_cfg(CFG_ROW_COUNT, 4'd15);
        write_cfg(CFG_COL_COUNT, 4'd15);
        send_item(OP_READ, 4'd7, 4'd8, '0);
        send_item(OP_READ, 4'd8, 4'd0, '0);
        send_item(OP_SOLVE, 4'd0, 4'd0, '0);
        drain();
    endtask

    // one small system: config, fill, solve, read back, with some noise mixed in
    task automatic run_system();
        int rows, cols;
        rows = ($urandom_range(0, 9) == 0) ? 8 : $urandom_range(1, 4);
        cols = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : rows + 1;
        write_cfg(CFG_ROW_COUNT, ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                              : 4'(rows));
        write_cfg(CFG_COL_COUNT, ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                              : 4'(cols));
        for (int r = 0; r < rows_used(); r++) begin
            for (int c = 0; c < cols_used(); c++) begin
                send_item(OP_WRITE, 4'(r), 4'(c), rand_q());
                if ($urandom_range(0, 9) == 0)
                    send_item(2'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)), $urandom);
            end
        end
        if ($urandom_range(0, 11) == 0)
            send_item(OP_UNUSED, 4'($urandom), 4'($urandom), $urandom);
        send_item(OP_SOLVE, 4'($urandom), 4'($urandom), $urandom);
        repeat ($urandom_range(2, 6))
            send_item(OP_READ, 4'($urandom_range(0, rows_used())),
                      4'($urandom_range(0, cols_used())), $urandom);
        if ($urandom_range(0, 4) == 0) send_item(OP_SOLVE, '0, '0, '0);
    endtask

    task automatic test_random(int pct, int count);
        int target;
        gap_pct = pct;
        target = items_sent + count;
        while (items_sent < target) run_system();
    endtask

    initial begin
        int wait_cycles;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_store();
        test_directed();
        test_random(24, 170);
        test_random(53, 170);
        test_random(0, 170);
        i_start <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (50) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            if (pending_results.size() != 0)
                $display("%0t: %0d results never arrived", $time, pending_results.size());
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #300ms;
        $display("simulation failed");
        $finish;
    end

endmodule
